@@ rtl/interval_sort_merge_core_assert.svh @@
// ----------------------------------------------------------------------------
// interval_sort_merge_core assertion macros
// Shared property shorthands for the checker of the range merge core.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SORT_MERGE_CORE_ASSERT_SVH
`define INTERVAL_SORT_MERGE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ISM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval_sort_merge_core check failed");

// next-cycle implication, disabled in reset
`define ISM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval_sort_merge_core check failed");

`endif

@@ rtl/ism_pkg.sv @@
// ----------------------------------------------------------------------------
// ism_pkg
// Types and constants shared by the interval sort/merge core.
// ----------------------------------------------------------------------------
package ism_pkg;

   localparam int MAX_RANGES = 16;
   localparam int VAL_W      = 53;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      val_type lo;
      val_type hi;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;   // store incoming range
      logic load;     // head -> current merged range
      logic absorb;   // head overlaps, widen current high
      logic split;    // emit current, head starts new range
      logic finish;   // emit last range, end batch
      logic clear;    // end batch with nothing stored
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cnt_zero;
      logic overlap;
      logic out_free;
   } status_type;

endpackage

@@ rtl/ism_channel_ifs.sv @@
// ----------------------------------------------------------------------------
// ism channel interfaces
// Valid/ready channels for range requests and merged range responses.
// ----------------------------------------------------------------------------
interface ism_req_if;
   logic             valid;
   logic             ready;
   ism_pkg::val_type range_low;
   ism_pkg::val_type range_high;
   logic             batch_end;

   modport source (output valid, range_low, range_high, batch_end, input ready);
   modport sink   (input valid, range_low, range_high, batch_end, output ready);
endinterface

interface ism_rsp_if;
   logic             valid;
   logic             ready;
   ism_pkg::val_type merged_low;
   ism_pkg::val_type merged_high;
   logic             final_range;
   logic             overflowed;

   modport source (output valid, merged_low, merged_high, final_range, overflowed,
                   input ready);
   modport sink   (input valid, merged_low, merged_high, final_range, overflowed,
                   output ready);
endinterface

@@ rtl/ism_ctrl.sv @@
// ----------------------------------------------------------------------------
// ism_ctrl
// Batch controller: accepts ranges, then walks the store to merge them.
// ----------------------------------------------------------------------------
module ism_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  ism_pkg::status_type sts,
   output ism_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MERGE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.cnt_zero) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.load = 1'b1;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (sts.cnt_zero) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (sts.overlap) begin
               cmd.absorb = 1'b1;
            end else if (sts.out_free) begin
               cmd.split = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ism_datapath.sv @@
// ----------------------------------------------------------------------------
// ism_datapath
// Sorted range store with parallel insert, merge walker and output register.
// ----------------------------------------------------------------------------
module ism_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ism_pkg::cmd_type    cmd,
   output ism_pkg::status_type sts,
   input  ism_pkg::val_type    new_lo,
   input  ism_pkg::val_type    new_hi,
   input  logic                out_ready,
   output logic                out_valid,
   output ism_pkg::val_type    out_lo,
   output ism_pkg::val_type    out_hi,
   output logic                out_final,
   output logic                out_ovf
);

   localparam int N = ism_pkg::MAX_RANGES;

   ism_pkg::entry_type entries_ff [N];
   ism_pkg::entry_type entries_in [N];
   ism_pkg::cnt_type   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   ism_pkg::val_type   cur_lo_ff, cur_lo_in;
   ism_pkg::val_type   cur_hi_ff, cur_hi_in;
   logic               out_valid_ff, out_valid_in;
   ism_pkg::val_type   out_lo_ff, out_lo_in;
   ism_pkg::val_type   out_hi_ff, out_hi_in;
   logic               out_final_ff, out_final_in;
   logic               out_ovf_ff, out_ovf_in;

   logic [N-1:0] gt;       // entry sorts strictly after the new range
   logic         full;
   logic         shift;
   logic         stored;

   assign full   = (cnt_ff == ism_pkg::CNT_W'(N));
   assign shift  = cmd.load | cmd.absorb | cmd.split;
   assign stored = cmd.insert & ~full;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         gt[i] = (ism_pkg::CNT_W'(i) < cnt_ff) &&
                 ((entries_ff[i].lo > new_lo) ||
                  ((entries_ff[i].lo == new_lo) && (entries_ff[i].hi > new_hi)));
      end
   end

   // store update: shift toward the head, or open a slot and insert
   always_comb begin
      for (int i = 0; i < N; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (shift) begin
         for (int i = 0; i < N - 1; i++) begin
            entries_in[i] = entries_ff[i + 1];
         end
      end else if (stored) begin
         for (int i = 0; i < N; i++) begin
            if (gt[i] || (ism_pkg::CNT_W'(i) == cnt_ff)) begin
               entries_in[i].lo = new_lo;
               entries_in[i].hi = new_hi;
            end
         end
         // entries after the insert point move up one slot
         for (int i = 1; i < N; i++) begin
            if (gt[i - 1]) begin
               entries_in[i] = entries_ff[i - 1];
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (stored) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (shift) begin
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.finish || cmd.clear) begin
         cnt_in = '0;
      end

      ovf_in = ovf_ff;
      if (cmd.insert && full) begin
         ovf_in = 1'b1;
      end else if (cmd.finish || cmd.clear) begin
         ovf_in = 1'b0;
      end

      cur_lo_in = cur_lo_ff;
      cur_hi_in = cur_hi_ff;
      if (cmd.load || cmd.split) begin
         cur_lo_in = entries_ff[0].lo;
         cur_hi_in = entries_ff[0].hi;
      end else if (cmd.absorb && (entries_ff[0].hi > cur_hi_ff)) begin
         cur_hi_in = entries_ff[0].hi;
      end

      out_lo_in    = out_lo_ff;
      out_hi_in    = out_hi_ff;
      out_final_in = out_final_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff & ~out_ready;
      if (cmd.split || cmd.finish) begin
         out_valid_in = 1'b1;
         out_lo_in    = cur_lo_ff;
         out_hi_in    = cur_hi_ff;
         out_final_in = cmd.finish;
         out_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      cur_lo_ff    <= cur_lo_in;
      cur_hi_ff    <= cur_hi_in;
      out_lo_ff    <= out_lo_in;
      out_hi_ff    <= out_hi_in;
      out_final_ff <= out_final_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.overlap  = (entries_ff[0].lo <= cur_hi_ff);
   assign sts.out_free = ~out_valid_ff | out_ready;

   assign out_valid = out_valid_ff;
   assign out_lo    = out_lo_ff;
   assign out_hi    = out_hi_ff;
   assign out_final = out_final_ff;
   assign out_ovf   = out_ovf_ff;

endmodule

@@ rtl/interval_sort_merge_core.sv @@
// ----------------------------------------------------------------------------
// interval_sort_merge_core
// Sorts a batch of half-open ranges and emits the merged, ascending ranges.
// ----------------------------------------------------------------------------
// Ranges arrive one per req transfer and are kept sorted by low bound, then
// high bound, in a register store of ism_pkg::MAX_RANGES entries. Every
// entry compares against the incoming range at once, so each accepted range
// goes straight into its sorted slot and req stays ready while the batch is
// being collected. The transfer with batch_end set closes the batch: req
// drops its ready, the store is walked from the head, one stored range per
// cycle unless a push waits on the output register, and each range that does
// not touch the current merged range pushes the current one out through a
// one-deep output register. After its last transfer a batch holds req not
// ready through a load step, a walk step per further stored range and a step
// to emit the last range, and while the rsp side stalls. The last response
// of the batch carries final_range. Ranges beyond the store depth are
// dropped; every response of such a batch has overflowed set. Ranges with
// high below low are kept as given, and a merged high never decreases.
// ----------------------------------------------------------------------------
module interval_sort_merge_core (
   input logic       clock,
   input logic       reset,
   ism_req_if.sink   req_chan,
   ism_rsp_if.source rsp_chan
);

   ism_pkg::cmd_type    cmd;     // walker commands
   ism_pkg::status_type sts;     // store / output status

   // batch controller: collects ranges, then sequences the merge walk
   ism_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.batch_end),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // sorted store, merge registers and response register
   ism_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .new_lo    (req_chan.range_low),
      .new_hi    (req_chan.range_high),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_lo    (rsp_chan.merged_low),
      .out_hi    (rsp_chan.merged_high),
      .out_final (rsp_chan.final_range),
      .out_ovf   (rsp_chan.overflowed)
   );

endmodule

@@ rtl/ism_checker.sv @@
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks on the interval sort/merge core, bound to the top level.
// ----------------------------------------------------------------------------
`include "interval_sort_merge_core_assert.svh"

module ism_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ism_pkg::val_type rsp_lo,
   input ism_pkg::val_type rsp_hi,
   input logic             rsp_final
);

   // a stalled response holds
   `ISM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_lo) && $stable(rsp_hi) && $stable(rsp_final))

   // closing a batch stops intake for the merge walk
   `ISM_ASSERT_NEXT(a_close_busy, clock, reset, req_valid && req_ready && req_last, !req_ready)

   // mid-batch transfers keep intake open
   `ISM_ASSERT_NEXT(a_collect_open, clock, reset, req_valid && req_ready && !req_last, req_ready)

   // a non-final response only exists while the walk is running
   `ISM_ASSERT_SAME(a_mid_busy, clock, reset, rsp_valid && !rsp_final, !req_ready)

endmodule

bind interval_sort_merge_core ism_checker u_ism_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.batch_end),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_lo    (rsp_chan.merged_low),
   .rsp_hi    (rsp_chan.merged_high),
   .rsp_final (rsp_chan.final_range)
);

@@ bench/tb_interval_sort_merge_core.sv @@
// ----------------------------------------------------------------------------
// tb_interval_sort_merge_core
// Self-checking bench for the range sort/merge core: drives batches of
// ranges, predicts the merged output batch by batch, checks every response.
// ----------------------------------------------------------------------------
module tb_interval_sort_merge_core;

   localparam int               HALF_PERIOD = 6;
   localparam int               RESET_CYCLES = 3;
   localparam int               END_SETTLE = 40;      // well past the batch walk
   localparam int               RUN_LIMIT = 3000000;
   localparam int               MAX_SHOWN = 10;
   localparam int               HOLD_CYCLES = 300;
   localparam ism_pkg::val_type TOP_VALUE = '1;

   // one merged range as it should leave the core
   typedef struct {
      ism_pkg::val_type lo;
      ism_pkg::val_type hi;
      logic             fin;
      logic             ovf;
   } merged_span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ism_req_if req_chan();
   ism_rsp_if rsp_chan();

   interval_sort_merge_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: the sorted store of the current batch, as the core
   // should hold it. Entries at or above held_count are never read.
   // ------------------------------------------------------------------------
   ism_pkg::val_type held_lows  [ism_pkg::MAX_RANGES];
   ism_pkg::val_type held_highs [ism_pkg::MAX_RANGES];
   int               held_count = 0;
   logic             batch_dropped = 1'b0;
   merged_span_type  pending_spans[$];   // merged ranges still owed by the core
   int               mismatch_count = 0;

   // stimulus knobs
   bit quiet_mode = 1'b0;     // no idling on either side
   bit sender_gaps = 1'b1;    // sender may pause between transfers
   int rsp_hold_left = 0;     // long receiver hold-off, counted down per cycle

   // Insert one accepted range; on the batch end walk the store and queue
   // the merged ranges that must come out.
   function automatic void predict_merge(ism_pkg::val_type lo, ism_pkg::val_type hi,
                                         logic last);
      int               pos;
      ism_pkg::val_type run_lo;
      ism_pkg::val_type run_hi;
      merged_span_type  span;
      if (held_count >= ism_pkg::MAX_RANGES) begin
         batch_dropped = 1'b1;       // store full: range is lost, batch flagged
      end else begin
         pos = held_count;
         // equal lows order by high, so the result never depends on arrival order
         while (pos > 0 && (held_lows[pos-1] > lo ||
                (held_lows[pos-1] == lo && held_highs[pos-1] > hi))) begin
            held_lows[pos]  = held_lows[pos-1];
            held_highs[pos] = held_highs[pos-1];
            pos--;
         end
         held_lows[pos]  = lo;
         held_highs[pos] = hi;
         held_count++;
      end
      if (!last) return;
      if (held_count > 0) begin
         run_lo = held_lows[0];
         run_hi = held_highs[0];
         for (int i = 1; i < held_count; i++) begin
            if (held_lows[i] <= run_hi) begin
               // overlap or touch; an inverted range never pulls the high down
               if (held_highs[i] > run_hi) run_hi = held_highs[i];
            end else begin
               span = '{run_lo, run_hi, 1'b0, batch_dropped};
               pending_spans.insert(pending_spans.size(), span);
               run_lo = held_lows[i];
               run_hi = held_highs[i];
            end
         end
         span = '{run_lo, run_hi, 1'b1, batch_dropped};
         pending_spans.insert(pending_spans.size(), span);
      end
      held_count    = 0;
      batch_dropped = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge. Request transfers
   // feed the predictor before the response of the same edge is checked.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      merged_span_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            predict_merge(req_chan.range_low, req_chan.range_high, req_chan.batch_end);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_spans.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("unexpected response: low=%0h high=%0h final=%0b ovf=%0b",
                           rsp_chan.merged_low, rsp_chan.merged_high,
                           rsp_chan.final_range, rsp_chan.overflowed);
            end else begin
               want = pending_spans.pop_front();
               if (rsp_chan.merged_low !== want.lo || rsp_chan.merged_high !== want.hi ||
                   rsp_chan.final_range !== want.fin || rsp_chan.overflowed !== want.ovf)
               begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_SHOWN)
                     $display({"response mismatch: expected low=%0h high=%0h final=%0b ",
                               "ovf=%0b, got low=%0h high=%0h final=%0b ovf=%0b"},
                              want.lo, want.hi, want.fin, want.ovf,
                              rsp_chan.merged_low, rsp_chan.merged_high,
                              rsp_chan.final_range, rsp_chan.overflowed);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge. Random bursts of stall
   // and ready, a long hold-off when a test asks for one, always ready in
   // quiet mode.
   // ------------------------------------------------------------------------
   initial begin
      int burst;
      burst = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            rsp_hold_left--;
         end else if (quiet_mode) begin
            rsp_chan.ready = 1'b1;
         end else if (burst > 0) begin
            burst--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_chan.ready = 1'b0;
            burst = $urandom_range(1, 19) - 1;
         end else begin
            rsp_chan.ready = 1'b1;
            burst = $urandom_range(1, 40) - 1;
         end
      end
   end

   // Offer one range and hold it until the transfer. Called at a falling
   // edge; returns at a falling edge with valid still high, so a follow-on
   // call simply overwrites the payload.
   task automatic send_range(ism_pkg::val_type lo, ism_pkg::val_type hi, logic last);
      if (sender_gaps && !quiet_mode && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.range_low  = lo;
      req_chan.range_high = hi;
      req_chan.batch_end  = last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Random range around a batch base: mostly clustered so overlaps are
   // common, plus full-width values, extremes and inverted ranges.
   function automatic void pick_range(input ism_pkg::val_type base,
                                      output ism_pkg::val_type lo,
                                      output ism_pkg::val_type hi);
      case ($urandom_range(0, 9))
         0, 1: begin
            lo = ism_pkg::val_type'({$urandom, $urandom});
            hi = ism_pkg::val_type'({$urandom, $urandom});
         end
         2: begin
            lo = ($urandom_range(0, 1) != 0) ? TOP_VALUE : '0;
            hi = ($urandom_range(0, 1) != 0) ? TOP_VALUE : '0;
         end
         3: begin
            lo = base + ism_pkg::val_type'($urandom_range(0, 40));
            hi = lo - ism_pkg::val_type'($urandom_range(1, 8));
         end
         default: begin
            lo = base + ism_pkg::val_type'($urandom_range(0, 120));
            hi = lo + ism_pkg::val_type'($urandom_range(0, 30));
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Full-span single range, then one batch covering disjoint, touching,
   // zero-width, inverted and top-of-range entries.
   task automatic test_directed_edges();
      send_range('0, TOP_VALUE, 1'b1);
      send_range(TOP_VALUE, TOP_VALUE, 1'b0);
      send_range(ism_pkg::val_type'(20), ism_pkg::val_type'(30), 1'b0);
      send_range('0, '0, 1'b0);
      send_range(ism_pkg::val_type'(10), ism_pkg::val_type'(20), 1'b0);   // touches [20,30)
      send_range(ism_pkg::val_type'(100), ism_pkg::val_type'(50), 1'b0);  // inverted, alone
      send_range(ism_pkg::val_type'(65), ism_pkg::val_type'(62), 1'b0);   // inverted, absorbed
      send_range(ism_pkg::val_type'(60), ism_pkg::val_type'(70), 1'b1);
   endtask

   // Seventeen ranges into a sixteen-deep store: the batch-end transfer
   // itself is dropped and every response is flagged. Equal lows arrive
   // out of high order, later lows descend to force deep shifts.
   task automatic test_store_overflow();
      ism_pkg::val_type lo;
      send_range(ism_pkg::val_type'(30), ism_pkg::val_type'(40), 1'b0);
      send_range(ism_pkg::val_type'(30), ism_pkg::val_type'(35), 1'b0);
      send_range(ism_pkg::val_type'(30), ism_pkg::val_type'(45), 1'b0);
      send_range(ism_pkg::val_type'(45), ism_pkg::val_type'(45), 1'b0);
      for (int i = 0; i < ism_pkg::MAX_RANGES - 4; i++) begin
         lo = ism_pkg::val_type'(1000 - 50 * i);
         send_range(lo, lo + ism_pkg::val_type'((i % 3 == 0) ? 60 : 20), 1'b0);
      end
      send_range(ism_pkg::val_type'(7), ism_pkg::val_type'(9), 1'b1);
   endtask

   // Receiver holds off while full batches keep coming: the output
   // register fills, the walk stalls, and req loses ready.
   task automatic test_back_pressure();
      ism_pkg::val_type base;
      ism_pkg::val_type lo;
      ism_pkg::val_type hi;
      sender_gaps   = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      for (int b = 0; b < 3; b++) begin
         base = ism_pkg::val_type'($urandom_range(0, 5000));
         for (int k = 0; k < ism_pkg::MAX_RANGES; k++) begin
            pick_range(base, lo, hi);
            send_range(lo, hi, k == ism_pkg::MAX_RANGES - 1);
         end
      end
      sender_gaps = 1'b1;
   endtask

   // Random batches: mostly small, about one in ten near or past the store depth.
   task automatic test_random_batches(int item_goal);
      int               sent;
      int               size;
      ism_pkg::val_type base;
      ism_pkg::val_type lo;
      ism_pkg::val_type hi;
      sent = 0;
      while (sent < item_goal) begin
         size = ($urandom_range(0, 9) == 0) ?
                $urandom_range(ism_pkg::MAX_RANGES - 2, ism_pkg::MAX_RANGES + 4) :
                $urandom_range(1, 8);
         base = ($urandom_range(0, 1) != 0) ? ism_pkg::val_type'({$urandom, $urandom})
                                            : ism_pkg::val_type'($urandom_range(0, 500));
         sender_gaps = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < size; k++) begin
            pick_range(base, lo, hi);
            send_range(lo, hi, k == size - 1);
         end
         sent += size;
      end
      sender_gaps = 1'b1;
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_streaming(int item_goal);
      quiet_mode = 1'b1;
      test_random_batches(item_goal);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.range_low  = '0;
      req_chan.range_high = '0;
      req_chan.batch_end  = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_store_overflow();
      test_back_pressure();
      test_random_batches(400);
      test_streaming(60);

      req_chan.valid = 1'b0;
      while (pending_spans.size() != 0) @(negedge clock);
      repeat (END_SETTLE) @(negedge clock);

      if (mismatch_count == 0 && pending_spans.size() == 0)
         $display("interval_sort_merge_core verification clean");
      else
         $display("interval_sort_merge_core verification failed");
      $finish;
   end

   // hang guard
   initial begin
      #RUN_LIMIT;
      $display("interval_sort_merge_core verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ism_pkg.sv
rtl/ism_channel_ifs.sv
rtl/ism_ctrl.sv
rtl/ism_datapath.sv
rtl/interval_sort_merge_core.sv
rtl/ism_checker.sv
bench/tb_interval_sort_merge_core.sv
